[hdl/vdr_pkg.sv]
// Shared types and constants of the vertex deduplication and remapping unit.
package vdr_pkg;

	localparam int MAX_VERTS = 1024;
	localparam int IDX_W = $clog2(MAX_VERTS);
	localparam int CNT_W = $clog2(MAX_VERTS + 1);
	localparam int COORD_W = 64;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_CORNER = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [COORD_W-1:0] coord_z;
		logic [IDX_W-1:0] corner_index;
	} vdr_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] new_index;
		logic is_new;
		logic [IDX_W-1:0] first_index;
		logic [CNT_W-1:0] unique_count;
		logic overflow;
	} vdr_rsp_t;

	typedef struct packed {
		logic vld;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [IDX_W-1:0] orig;
		logic found;
		logic is_new;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] first;
		logic [CNT_W-1:0] uc;
	} vdr_probe_t;

	typedef struct packed {
		logic adv;
		logic clr;
	} vdr_ctl_t;

endpackage

[hdl/vdr_cell.sv]
// One cell of the compare chain: holds one unique vertex and passes the probe along.
module vdr_cell
	import vdr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input vdr_ctl_t ctl,
	input logic [IDX_W-1:0] cell_idx,
	input vdr_probe_t prev,
	output vdr_probe_t probe
);

	logic occ_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [COORD_W-1:0] z_q;
	logic [IDX_W-1:0] first_q;
	logic vld_q;
	vdr_probe_t pay_q;
	vdr_probe_t nxt;
	logic seek;
	logic hit;
	logic ins;

	assign seek = prev.vld && !prev.found;
	assign hit = seek && occ_q && (x_q == prev.x) && (y_q == prev.y) && (z_q == prev.z);
	assign ins = seek && !occ_q;

	always_comb begin
		nxt = prev;
		if (hit) begin
			nxt.found = 1'b1;
			nxt.is_new = 1'b0;
			nxt.idx = cell_idx;
			nxt.first = first_q;
		end
		if (ins) begin
			nxt.found = 1'b1;
			nxt.is_new = 1'b1;
			nxt.idx = cell_idx;
			nxt.first = prev.orig;
		end
		if (prev.vld && (occ_q || ins)) begin
			nxt.uc = CNT_W'(cell_idx) + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				occ_q <= 1'b0;
			end else if (ctl.adv && ins) begin
				occ_q <= 1'b1;
			end
			if (ctl.adv) begin
				vld_q <= prev.vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			pay_q <= nxt;
		end
		if (ctl.adv && ins) begin
			x_q <= prev.x;
			y_q <= prev.y;
			z_q <= prev.z;
			first_q <= prev.orig;
		end
	end

	always_comb begin
		probe = pay_q;
		probe.vld = vld_q;
	end

endmodule

[hdl/vertex_dedup_remap_unit.sv]
// Top level of the vertex deduplication and remapping unit.
//
// Requests arrive as one word on req_valid/req_stall/req_word and each request
// gives exactly one word on rsp_valid/rsp_stall/rsp_word, in request order.
// A vertex load enters a chain of MAX_VERTS cells, one cell per cycle unless a
// response stalls; each cell compares the vertex with the unique vertex it
// holds, and the first empty cell takes a vertex that matched nothing. Its
// response goes from the last cell to the output register, and loads stream
// in at one per cycle while idle and unstalled. A face corner lookup, a clear,
// an unused code and a load into a full table wait until the chain is empty.
// A clear, an unused code, a load into a full table or a corner that names an
// unloaded vertex then answers in the next cycle. A corner lookup of a loaded
// vertex answers after two dependent reads of the remap and first-occurrence
// memories. A stalled response freezes the whole chain, so the request side
// stalls too; nothing is lost. Reset empties the chain and the output register
// and zeroes the loaded, unique and in-flight counts; memory contents stay.
module vertex_dedup_remap_unit
	import vdr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input vdr_req_t req_word,
	output logic rsp_valid,
	input logic rsp_stall,
	output vdr_rsp_t rsp_word
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_SEND = 2'd2;

	function automatic logic [COORD_W-1:0] norm_zero(input logic [COORD_W-1:0] v);
		norm_zero = (v == {1'b1, {(COORD_W-1){1'b0}}}) ? '0 : v;
	endfunction

	logic [1:0] state_q;
	logic [CNT_W-1:0] loaded_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] inflight_q;
	logic rsp_vld_q;
	vdr_rsp_t rsp_q;
	logic [IDX_W-1:0] remap_rd_q;
	logic [IDX_W-1:0] first_rd_q;
	logic [IDX_W-1:0] remap_mem [MAX_VERTS];
	logic [IDX_W-1:0] first_mem [MAX_VERTS];

	logic adv;
	logic is_load;
	logic full;
	logic stream_ok;
	logic op_ok;
	logic acc;
	logic stream_acc;
	logic op_acc;
	logic corner_go;
	logic emit_op;
	logic exit_go;
	vdr_rsp_t op_word;
	vdr_ctl_t ctl;
	vdr_probe_t head;
	vdr_probe_t tail;
	vdr_probe_t link [MAX_VERTS+1];

	assign adv = !rsp_vld_q || !rsp_stall;
	assign is_load = (req_word.func == FUNC_LOAD);
	assign full = (loaded_q >= CNT_W'(MAX_VERTS));
	assign stream_ok = (state_q == ST_IDLE) && adv;
	assign op_ok = (state_q == ST_IDLE) && adv && (inflight_q == '0);
	assign req_stall = (is_load && !full) ? !stream_ok : !op_ok;
	assign acc = req_valid && !req_stall;
	assign stream_acc = acc && is_load && !full;
	assign op_acc = acc && !stream_acc;
	assign corner_go = op_acc && (req_word.func == FUNC_CORNER)
		&& (CNT_W'(req_word.corner_index) < loaded_q);
	assign emit_op = op_acc && !corner_go;
	assign exit_go = tail.vld && adv;

	assign ctl.adv = adv;
	assign ctl.clr = op_acc && (req_word.func == FUNC_CLEAR);

	always_comb begin
		head = '0;
		head.vld = stream_acc;
		head.x = norm_zero(req_word.coord_x);
		head.y = norm_zero(req_word.coord_y);
		head.z = norm_zero(req_word.coord_z);
		head.orig = loaded_q[IDX_W-1:0];
	end

	assign link[0] = head;

	for (genvar i = 0; i < MAX_VERTS; i++) begin : g_cell
		vdr_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.cell_idx(IDX_W'(i)),
			.prev(link[i]),
			.probe(link[i+1])
		);
	end

	assign tail = link[MAX_VERTS];

	always_comb begin
		op_word = '0;
		op_word.unique_count = count_q;
		unique case (req_word.func)
			FUNC_LOAD: begin
				op_word.overflow = 1'b1;
			end
			FUNC_CORNER: begin
				op_word.overflow = 1'b1;
			end
			FUNC_CLEAR: begin
				op_word.unique_count = '0;
			end
			FUNC_NONE: begin
				op_word.overflow = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			loaded_q <= '0;
			count_q <= '0;
			inflight_q <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (corner_go) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ctl.clr) begin
				loaded_q <= '0;
			end else if (stream_acc) begin
				loaded_q <= loaded_q + CNT_W'(1);
			end
			if (ctl.clr) begin
				count_q <= '0;
			end else if (exit_go) begin
				count_q <= tail.uc;
			end
			inflight_q <= inflight_q + CNT_W'(stream_acc) - CNT_W'(exit_go);
			if (adv) begin
				rsp_vld_q <= tail.vld || emit_op || (state_q == ST_SEND);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (tail.vld) begin
				rsp_q.new_index <= tail.idx;
				rsp_q.is_new <= tail.is_new;
				rsp_q.first_index <= tail.first;
				rsp_q.unique_count <= tail.uc;
				rsp_q.overflow <= 1'b0;
			end else if (emit_op) begin
				rsp_q <= op_word;
			end else if (state_q == ST_SEND) begin
				rsp_q.new_index <= remap_rd_q;
				rsp_q.is_new <= 1'b0;
				rsp_q.first_index <= first_rd_q;
				rsp_q.unique_count <= count_q;
				rsp_q.overflow <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exit_go) begin
			remap_mem[tail.orig] <= tail.idx;
		end
		if (corner_go) begin
			remap_rd_q <= remap_mem[req_word.corner_index];
		end
	end

	always_ff @(posedge clk) begin
		if (exit_go && tail.is_new) begin
			first_mem[tail.idx] <= tail.first;
		end
		if (state_q == ST_READ) begin
			first_rd_q <= first_mem[remap_rd_q];
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_word = rsp_q;

	a_exit_found: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> tail.found)
		else $error("A load left the chain without a match or an insertion.");

	a_new_at_frontier: assert property (@(posedge clk) disable iff (!arst_n)
		(tail.vld && tail.is_new) |->
		((CNT_W'(tail.idx) == count_q) && (count_q < CNT_W'(MAX_VERTS))))
		else $error("A new vertex was not placed at the end of the unique list.");

	a_op_drained: assert property (@(posedge clk) disable iff (!arst_n)
		op_acc |-> ((inflight_q == '0) && !tail.vld))
		else $error("A non-streaming request was taken while loads were in the chain.");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> req_stall)
		else $error("A request was open to acceptance during a corner lookup.");

endmodule
